>>> rtl/core/rat_pkg.sv
// ----------------------------------------------------------------------------
// rat_pkg
// Types and codes shared by the admission table cells and its controller.
// ----------------------------------------------------------------------------
package rat_pkg;

    localparam int KEY_W    = 32;
    localparam int CPU_W    = 32;
    localparam int MEM_W    = 24;
    localparam int STATUS_W = 3;
    localparam int CORES_W  = 16;

    localparam logic OP_REGISTER   = 1'b0;
    localparam logic OP_UNREGISTER = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP_DIFF  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CPU_SHORT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MEM_SHORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd6;

    localparam logic [1:0] CFG_CPU_CORES     = 2'd0;
    localparam logic [1:0] CFG_CPU_UNLIMITED = 2'd1;
    localparam logic [1:0] CFG_MEM_CAPACITY  = 2'd2;
    localparam logic [1:0] CFG_MEM_UNLIMITED = 2'd3;

    // lookup token that walks the cell chain
    typedef struct packed {
        logic             active;
        logic             hit;
        logic             free;
        logic [KEY_W-1:0] key;
        logic [CPU_W-1:0] cpu;
        logic [MEM_W-1:0] mem;
    } tok_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [KEY_W-1:0] key;
        logic [CPU_W-1:0] cpu;
        logic [MEM_W-1:0] mem;
    } cmd_t;

endpackage

>>> rtl/core/resource_admission_table.sv
// ----------------------------------------------------------------------------
// resource_admission_table
// Admission table of registered clients with running cpu and memory totals.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  s_       | in  | s_tvalid / s_tready  | s_tdata: key, cpu units, mem MB; s_tuser: opcode
//  m_       | out | m_tvalid / m_tready  | m_tdata: status, cpu in use, mem MB in use
//  cfg_     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// m_tvalid rises after the request has passed the whole chain: the lookup
// token enters the first slot cell on the transfer edge and walks one cell per
// cycle, then the controller latches it at the tail and decides in S_DECIDE.
// One request is in flight at a time and s_tready stays low until the result
// transfer, so a new request is never taken before the last result is out, and
// a stalled m_tready holds off new ones.
// Synchronous reset clears all slots and both totals and sets both capacities to unlimited.
// ----------------------------------------------------------------------------
module resource_admission_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int CPU_SCALE   = 10000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // client_key, cpu_request_units, mem_request_mb
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // status, cpu_in_use_units, mem_in_use_mb, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    rat_pkg::tok_t    tok_chain [TABLE_DEPTH+1];
    logic [IDX_W-1:0] hit_chain [TABLE_DEPTH+1];
    logic [IDX_W-1:0] free_chain[TABLE_DEPTH+1];
    rat_pkg::cmd_t    cmd;
    logic [IDX_W-1:0] cmd_idx;

    assign hit_chain[0]  = '0;
    assign free_chain[0] = '0;

    rat_ctrl #(
        .IDX_W     (IDX_W),
        .CPU_SCALE (CPU_SCALE)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head_tok      (tok_chain[0]),
        .tail_tok      (tok_chain[TABLE_DEPTH]),
        .tail_hit_idx  (hit_chain[TABLE_DEPTH]),
        .tail_free_idx (free_chain[TABLE_DEPTH]),
        .cmd           (cmd),
        .cmd_idx       (cmd_idx)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        rat_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .tok_in       (tok_chain[i]),
            .hit_idx_in   (hit_chain[i]),
            .free_idx_in  (free_chain[i]),
            .tok_out      (tok_chain[i+1]),
            .hit_idx_out  (hit_chain[i+1]),
            .free_idx_out (free_chain[i+1]),
            .cmd          (cmd),
            .cmd_idx      (cmd_idx)
        );
    end

endmodule

>>> rtl/core/rat_cell.sv
// ----------------------------------------------------------------------------
// rat_cell
// One table slot: holds an entry and forwards the lookup token to the next
// slot, marking the first key hit and the first free slot it passes.
// ----------------------------------------------------------------------------
module rat_cell #(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rat_pkg::tok_t     tok_in,
    input  logic [IDX_W-1:0]  hit_idx_in,
    input  logic [IDX_W-1:0]  free_idx_in,
    output rat_pkg::tok_t     tok_out,
    output logic [IDX_W-1:0]  hit_idx_out,
    output logic [IDX_W-1:0]  free_idx_out,
    input  rat_pkg::cmd_t     cmd,
    input  logic [IDX_W-1:0]  cmd_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic                      valid_reg;
    logic [rat_pkg::KEY_W-1:0] key_reg;
    logic [rat_pkg::CPU_W-1:0] cpu_reg;
    logic [rat_pkg::MEM_W-1:0] mem_reg;

    rat_pkg::tok_t    tok_reg, tok_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             sel;

    assign sel = (cmd_idx == MY_IDX);

    always_comb begin
        tok_next      = tok_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (valid_reg && !tok_in.hit && key_reg == tok_in.key) begin
            tok_next.hit = 1'b1;
            tok_next.cpu = cpu_reg;
            tok_next.mem = mem_reg;
            hit_idx_next = MY_IDX;
        end
        if (!valid_reg && !tok_in.free) begin
            tok_next.free = 1'b1;
            free_idx_next = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (sel && cmd.wr) begin
            valid_reg <= 1'b1;
        end else if (sel && cmd.clr) begin
            valid_reg <= 1'b0;
        end
        if (sel && cmd.wr) begin
            key_reg <= cmd.key;
            cpu_reg <= cmd.cpu;
            mem_reg <= cmd.mem;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

>>> rtl/core/rat_ctrl.sv
// ----------------------------------------------------------------------------
// rat_ctrl
// Request sequencer: launches the lookup token, takes its result at the tail
// of the chain, runs the admission checks and updates table and totals.
// ----------------------------------------------------------------------------
module rat_ctrl #(
    parameter int IDX_W     = 6,
    parameter int CPU_SCALE = 10000
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [87:0]                   s_tdata,
    input  logic                          s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [23:0]                   cfg_data,
    // chain head and tail
    output rat_pkg::tok_t                 head_tok,
    input  rat_pkg::tok_t                 tail_tok,
    input  logic [IDX_W-1:0]              tail_hit_idx,
    input  logic [IDX_W-1:0]              tail_free_idx,
    output rat_pkg::cmd_t                 cmd,
    output logic [IDX_W-1:0]              cmd_idx
);

    localparam int SCALE_W = $clog2(CPU_SCALE + 1);
    localparam int CAP_W   = rat_pkg::CORES_W + SCALE_W;
    localparam int CSUM_W  = rat_pkg::CPU_W + 1;
    localparam int MSUM_W  = rat_pkg::MEM_W + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [rat_pkg::CORES_W-1:0] cores_reg;
    logic                        cpu_unl_reg;
    logic [rat_pkg::MEM_W-1:0]   mem_cap_reg;
    logic                        mem_unl_reg;
    logic [CAP_W-1:0]            cpu_cap_reg;

    logic                        op_reg;
    logic [rat_pkg::CPU_W-1:0]   req_cpu_reg;
    logic [rat_pkg::MEM_W-1:0]   req_mem_reg;
    rat_pkg::tok_t               res_tok_reg;
    logic [IDX_W-1:0]            res_hit_idx_reg;
    logic [IDX_W-1:0]            res_free_idx_reg;

    logic [rat_pkg::CPU_W-1:0]   cpu_used_reg, cpu_used_next;
    logic [rat_pkg::MEM_W-1:0]   mem_used_reg, mem_used_next;
    logic [rat_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [CSUM_W-1:0] cpu_sum;
    logic [MSUM_W-1:0] mem_sum;
    logic              cpu_fits, mem_fits, same_demand, s_xfer;

    assign s_xfer    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'd0, mem_used_reg, cpu_used_reg, status_reg};

    always_comb begin
        head_tok        = '0;
        head_tok.active = s_xfer;
        head_tok.key    = s_tdata[31:0];
    end

    // configuration registers and scaled cpu capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cores_reg   <= '0;
            cpu_unl_reg <= 1'b1;
            mem_cap_reg <= '0;
            mem_unl_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rat_pkg::CFG_CPU_CORES:     cores_reg   <= cfg_data[15:0];
                rat_pkg::CFG_CPU_UNLIMITED: cpu_unl_reg <= cfg_data[0];
                rat_pkg::CFG_MEM_CAPACITY:  mem_cap_reg <= cfg_data;
                rat_pkg::CFG_MEM_UNLIMITED: mem_unl_reg <= cfg_data[0];
                default: ;
            endcase
        end
        cpu_cap_reg <= CAP_W'(cores_reg) * CAP_W'(CPU_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg      <= s_tuser;
            req_cpu_reg <= s_tdata[63:32];
            req_mem_reg <= s_tdata[87:64];
        end
        if (state_reg == S_SCAN && tail_tok.active) begin
            res_tok_reg      <= tail_tok;
            res_hit_idx_reg  <= tail_hit_idx;
            res_free_idx_reg <= tail_free_idx;
        end
    end

    // admission checks
    assign cpu_sum     = CSUM_W'(cpu_used_reg) + CSUM_W'(req_cpu_reg);
    assign mem_sum     = MSUM_W'(mem_used_reg) + MSUM_W'(req_mem_reg);
    assign cpu_fits    = (req_cpu_reg == '0) || (cpu_sum <= CSUM_W'(cpu_cap_reg));
    assign mem_fits    = (req_mem_reg == '0) || (mem_sum <= MSUM_W'(mem_cap_reg));
    assign same_demand = (res_tok_reg.cpu == req_cpu_reg) && (res_tok_reg.mem == req_mem_reg);

    always_comb begin
        status_next   = status_reg;
        cpu_used_next = cpu_used_reg;
        mem_used_next = mem_used_reg;
        cmd           = '0;
        cmd.key       = res_tok_reg.key;
        cmd.cpu       = req_cpu_reg;
        cmd.mem       = req_mem_reg;
        cmd_idx       = res_free_idx_reg;
        if (state_reg == S_DECIDE) begin
            if (op_reg == rat_pkg::OP_UNREGISTER) begin
                cmd_idx = res_hit_idx_reg;
                if (!res_tok_reg.hit) begin
                    status_next = rat_pkg::ST_NOT_FOUND;
                end else begin
                    status_next   = same_demand ? rat_pkg::ST_OK : rat_pkg::ST_MISMATCH;
                    cmd.clr       = 1'b1;
                    cpu_used_next = cpu_used_reg - res_tok_reg.cpu;
                    mem_used_next = mem_used_reg - res_tok_reg.mem;
                end
            end else if (res_tok_reg.hit) begin
                status_next = same_demand ? rat_pkg::ST_OK : rat_pkg::ST_DUP_DIFF;
            end else if (cpu_sum[CSUM_W-1] || (!cpu_unl_reg && !cpu_fits)) begin
                status_next = rat_pkg::ST_CPU_SHORT;
            end else if (mem_sum[MSUM_W-1] || (!mem_unl_reg && !mem_fits)) begin
                status_next = rat_pkg::ST_MEM_SHORT;
            end else if (!res_tok_reg.free) begin
                status_next = rat_pkg::ST_FULL;
            end else begin
                status_next   = rat_pkg::ST_OK;
                cmd.wr        = 1'b1;
                cpu_used_next = cpu_sum[rat_pkg::CPU_W-1:0];
                mem_used_next = mem_sum[rat_pkg::MEM_W-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_xfer) state_next = S_SCAN;
            S_SCAN:   if (tail_tok.active) state_next = S_DECIDE;
            S_DECIDE: state_next = S_OUT;
            S_OUT:    if (m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cpu_used_reg <= '0;
            mem_used_reg <= '0;
            status_reg   <= rat_pkg::ST_OK;
        end else begin
            state_reg    <= state_next;
            cpu_used_reg <= cpu_used_next;
            mem_used_reg <= mem_used_next;
            status_reg   <= status_next;
        end
    end

    a_ready_valid_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while a result is pending");

    a_totals_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_DECIDE) |=> $stable(cpu_used_reg) && $stable(mem_used_reg))
        else $error("totals changed outside the decision cycle");

    a_result_after_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_DECIDE)
        else $error("result shown without a decision");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status_reg <= rat_pkg::ST_MISMATCH)
        else $error("status code out of range");

    a_one_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr && cmd.clr))
        else $error("write and clear issued together");

endmodule

>>> sim/admission_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// admission_checker
// Watches the request, reply and register channels of the admission table,
// keeps its own copy of the client table and totals, predicts the reply to
// every accepted request and compares each reply field by field.
// ----------------------------------------------------------------------------
module admission_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int CPU_SCALE   = 10000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          mismatch_count,
    output int          replies_owed
);

    localparam int KEY_W    = rat_pkg::KEY_W;
    localparam int CPU_W    = rat_pkg::CPU_W;
    localparam int MEM_W    = rat_pkg::MEM_W;
    localparam int STATUS_W = rat_pkg::STATUS_W;
    localparam int CORES_W  = rat_pkg::CORES_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CPU_W-1:0]    cpu_used;
        logic [MEM_W-1:0]    mem_used;
    } reply_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CPU_W-1:0] cpu;
        logic [MEM_W-1:0] mem;
    } client_t;

    client_t            clients [TABLE_DEPTH];
    logic [CPU_W-1:0]   cpu_total;
    logic [MEM_W-1:0]   mem_total;
    logic [CORES_W-1:0] cpu_cores;
    logic               cpu_open;
    logic [MEM_W-1:0]   mem_cap;
    logic               mem_open;
    reply_t             predicted_replies [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int find_client(input logic [KEY_W-1:0] key);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (clients[i].valid && clients[i].key == key)
                return i;
        end
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!clients[i].valid)
                return i;
        end
        return -1;
    endfunction

    // room left saturates at zero once the capacity drops below the total
    function automatic logic room_for(input logic [63:0] cap, input logic [63:0] used,
                                      input logic [63:0] req);
        logic [63:0] room;
        room = (cap > used) ? cap - used : 64'd0;
        return req <= room;
    endfunction

    function automatic logic [STATUS_W-1:0] admit_request(input logic [KEY_W-1:0] key,
                                                          input logic [CPU_W-1:0] cpu,
                                                          input logic [MEM_W-1:0] mem);
        int          slot;
        logic [63:0] cpu_cap;
        slot = find_client(key);
        if (slot >= 0)
            return (clients[slot].cpu == cpu && clients[slot].mem == mem) ?
                   rat_pkg::ST_OK : rat_pkg::ST_DUP_DIFF;
        cpu_cap = 64'(cpu_cores) * 64'(CPU_SCALE);
        // counter overflow is refused even with no capacity set
        if (64'(cpu_total) + 64'(cpu) > 64'hFFFF_FFFF)
            return rat_pkg::ST_CPU_SHORT;
        if (!cpu_open && !room_for(cpu_cap, 64'(cpu_total), 64'(cpu)))
            return rat_pkg::ST_CPU_SHORT;
        if (64'(mem_total) + 64'(mem) > 64'hFF_FFFF)
            return rat_pkg::ST_MEM_SHORT;
        if (!mem_open && !room_for(64'(mem_cap), 64'(mem_total), 64'(mem)))
            return rat_pkg::ST_MEM_SHORT;
        slot = first_free_slot();
        if (slot < 0)
            return rat_pkg::ST_FULL;
        clients[slot] = '{valid: 1'b1, key: key, cpu: cpu, mem: mem};
        cpu_total += cpu;
        mem_total += mem;
        return rat_pkg::ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] retire_client(input logic [KEY_W-1:0] key,
                                                          input logic [CPU_W-1:0] cpu,
                                                          input logic [MEM_W-1:0] mem);
        int                  slot;
        logic [STATUS_W-1:0] st;
        slot = find_client(key);
        if (slot < 0)
            return rat_pkg::ST_NOT_FOUND;
        st = (clients[slot].cpu == cpu && clients[slot].mem == mem) ?
             rat_pkg::ST_OK : rat_pkg::ST_MISMATCH;
        // stored demands are subtracted even on a mismatch
        cpu_total -= clients[slot].cpu;
        mem_total -= clients[slot].mem;
        clients[slot].valid = 1'b0;
        return st;
    endfunction

    always @(posedge aclk) begin
        reply_t              got;
        reply_t              want;
        logic [STATUS_W-1:0] st;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                clients[i] = '0;
            cpu_total = '0;
            mem_total = '0;
            cpu_cores = '0;
            cpu_open  = 1'b1;
            mem_cap   = '0;
            mem_open  = 1'b1;
            predicted_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rat_pkg::CFG_CPU_CORES:     cpu_cores = cfg_data[CORES_W-1:0];
                    rat_pkg::CFG_CPU_UNLIMITED: cpu_open  = cfg_data[0];
                    rat_pkg::CFG_MEM_CAPACITY:  mem_cap   = cfg_data[MEM_W-1:0];
                    rat_pkg::CFG_MEM_UNLIMITED: mem_open  = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.status   = m_tdata[2:0];
                got.cpu_used = m_tdata[34:3];
                got.mem_used = m_tdata[58:35];
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with nothing predicted, status %0d",
                                              got.status));
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  got.status, want.status));
                    if (got.cpu_used != want.cpu_used)
                        report_mismatch($sformatf("cpu in use got 0x%0h expected 0x%0h",
                                                  got.cpu_used, want.cpu_used));
                    if (got.mem_used != want.mem_used)
                        report_mismatch($sformatf("mem in use got 0x%0h expected 0x%0h",
                                                  got.mem_used, want.mem_used));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == rat_pkg::OP_REGISTER)
                    st = admit_request(s_tdata[31:0], s_tdata[63:32], s_tdata[87:64]);
                else
                    st = retire_client(s_tdata[31:0], s_tdata[63:32], s_tdata[87:64]);
                predicted_replies.push_back(reply_t'{status: st, cpu_used: cpu_total,
                                                     mem_used: mem_total});
            end
        end
        replies_owed = predicted_replies.size();
    end

endmodule

>>> sim/tb_resource_admission_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resource_admission_table
// Drives register and unregister requests and capacity settings into the
// admission table: a directed opening at the reset settings, then random
// phases over a pool of client keys under several capacities, with random
// idling on both channels except in the last two phases. The checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_resource_admission_table;

    localparam int TABLE_DEPTH  = 64;
    localparam int CPU_SCALE    = 10000;
    localparam int POOL_SIZE    = 80;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 322;
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int KEY_W        = rat_pkg::KEY_W;
    localparam int CPU_W        = rat_pkg::CPU_W;
    localparam int MEM_W        = rat_pkg::MEM_W;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    int          mismatch_count;
    int          replies_owed;
    int          cycle_count = 0;
    int          send_idle_pct = 34;
    int          recv_idle_pct = 82;

    // client pool: each key keeps its demands until it is unregistered
    logic [KEY_W-1:0] pool_key [POOL_SIZE];
    logic [CPU_W-1:0] pool_cpu [POOL_SIZE];
    logic [MEM_W-1:0] pool_mem [POOL_SIZE];
    logic [CPU_W-1:0] cpu_max;
    logic [MEM_W-1:0] mem_max;

    resource_admission_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CPU_SCALE   (CPU_SCALE)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    admission_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CPU_SCALE   (CPU_SCALE)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // valid is left high on return so back-to-back requests need no toggle
    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [CPU_W-1:0] cpu, input logic [MEM_W-1:0] mem);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {mem, cpu, key};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // pause the sender until every reply is back and the table is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (replies_owed != 0)
            @(negedge aclk);
        repeat (TABLE_DEPTH + 8) @(negedge aclk);
    endtask

    function automatic logic [CPU_W-1:0] draw_cpu();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return $urandom;
        if (r == 2)
            return '1;
        return $urandom_range(1, cpu_max);
    endfunction

    function automatic logic [MEM_W-1:0] draw_mem();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return MEM_W'($urandom);
        if (r == 2)
            return '1;
        return MEM_W'($urandom_range(1, mem_max));
    endfunction

    task automatic set_phase(input int p);
        case (p)
            0: begin
                // upper bits of the core count and a cleared flag are masked off
                write_reg(rat_pkg::CFG_CPU_CORES, 24'hFF0064);
                write_reg(rat_pkg::CFG_CPU_UNLIMITED, 24'h000000);
                write_reg(rat_pkg::CFG_MEM_CAPACITY, 24'd4096);
                write_reg(rat_pkg::CFG_MEM_UNLIMITED, 24'hFFFFFE);
                cpu_max = 32'd60000;
                mem_max = 24'd300;
            end
            1: begin
                // zero capacity below what is in use: only zero demands fit
                write_reg(rat_pkg::CFG_CPU_CORES, 24'h000000);
                write_reg(rat_pkg::CFG_MEM_CAPACITY, 24'h000000);
                cpu_max = 32'd60000;
                mem_max = 24'd300;
            end
            2: begin
                write_reg(rat_pkg::CFG_CPU_CORES, 24'h00FFFF);
                write_reg(rat_pkg::CFG_MEM_CAPACITY, 24'hFFFFFF);
                cpu_max = 32'd8_000_000;
                mem_max = 24'd400_000;
            end
            3: begin
                write_reg(rat_pkg::CFG_CPU_CORES, 24'd1);
                write_reg(rat_pkg::CFG_MEM_CAPACITY, 24'd10);
                cpu_max = 32'd20000;
                mem_max = 24'd20;
            end
            4: begin
                write_reg(rat_pkg::CFG_CPU_CORES, 24'hABCDEF);
                write_reg(rat_pkg::CFG_CPU_UNLIMITED, 24'hFFFFFF);
                write_reg(rat_pkg::CFG_MEM_CAPACITY, 24'h123456);
                write_reg(rat_pkg::CFG_MEM_UNLIMITED, 24'h000001);
                cpu_max = '1;
                mem_max = '1;
            end
            default: begin
                write_reg(rat_pkg::CFG_CPU_CORES, 24'd500);
                write_reg(rat_pkg::CFG_CPU_UNLIMITED, 24'h000000);
                write_reg(rat_pkg::CFG_MEM_CAPACITY, 24'd100000);
                write_reg(rat_pkg::CFG_MEM_UNLIMITED, 24'h000000);
                cpu_max = 32'd60000;
                mem_max = 24'd1000;
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int               pick;
        logic             op;
        logic [KEY_W-1:0] key;
        logic [CPU_W-1:0] cpu;
        logic [MEM_W-1:0] mem;
        if ($urandom_range(0, 99) < 8) begin
            op  = 1'($urandom_range(0, 1));
            key = $urandom;
            cpu = $urandom;
            mem = MEM_W'($urandom);
        end else begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            key  = pool_key[pick];
            cpu  = pool_cpu[pick];
            mem  = pool_mem[pick];
            op   = ($urandom_range(0, 99) < 58) ? rat_pkg::OP_REGISTER : rat_pkg::OP_UNREGISTER;
            // some requests carry demands that differ from the stored ones
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) != 0)
                    cpu = cpu + 1 + $urandom_range(0, 99);
                else
                    mem = mem + 1'b1;
            end
            if (op == rat_pkg::OP_UNREGISTER) begin
                pool_cpu[pick] = draw_cpu();
                pool_mem[pick] = draw_mem();
            end
        end
        send_request(op, key, cpu, mem);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset settings, both capacities unlimited
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0000, 32'h0000_0000, 24'h000000);
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0000, 32'h0000_0000, 24'h000000);
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0000, 32'h0000_0001, 24'h000000);
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0000, 32'h0000_0000, 24'h000001);
        send_request(rat_pkg::OP_REGISTER,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0001, 32'h0000_0001, 24'h000000);
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0001, 32'h0000_0000, 24'h000001);
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0001, 32'h0000_0000, 24'h000000);
        send_request(rat_pkg::OP_UNREGISTER, 32'hFFFF_FFFF, 32'h0000_0000, 24'h000000);
        send_request(rat_pkg::OP_UNREGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
        send_request(rat_pkg::OP_UNREGISTER, 32'h0000_0000, 32'h0000_0000, 24'h000000);
        send_request(rat_pkg::OP_REGISTER,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 24'hA5A5A5);
        send_request(rat_pkg::OP_REGISTER,   32'h5A5A_5A5A, 32'hA5A5_A5A5, 24'h5A5A5A);
        send_request(rat_pkg::OP_REGISTER,   32'h0000_0002, 32'h0000_0001, 24'h000001);
        send_request(rat_pkg::OP_UNREGISTER, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 24'h5A5A5A);
        send_request(rat_pkg::OP_UNREGISTER, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 24'h5A5A5A);
        send_request(rat_pkg::OP_UNREGISTER, 32'h0000_0001, 32'h0000_0000, 24'h000000);
        send_request(rat_pkg::OP_UNREGISTER, 32'h0000_0002, 32'h0000_0001, 24'h000001);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct = 34;
                recv_idle_pct = 82;
            end else if (p < 4) begin
                send_idle_pct = 82;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_phase(p);
            @(negedge aclk);
            if (p == 0) begin
                for (int i = 0; i < POOL_SIZE; i++) begin
                    pool_key[i] = $urandom;
                    pool_cpu[i] = draw_cpu();
                    pool_mem[i] = draw_mem();
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request();
                if (n % 97 == 96)
                    drain();
            end
            drain();
        end

        if (mismatch_count == 0 && replies_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/rat_pkg.sv
rtl/core/rat_cell.sv
rtl/core/rat_ctrl.sv
rtl/core/resource_admission_table.sv
sim/admission_checker.sv
sim/tb_resource_admission_table.sv
